// ----- rtl/core/stm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package stm_pkg;

  // Field widths
  localparam int CH_W    = 8;
  localparam int PULSE_W = 12;
  localparam int TRIM_W  = 12;
  localparam int STEP_W  = 8;
  localparam int GAIN_W  = 8;
  localparam int MODE_W  = 2;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_MOVING = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRIM_A = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRIM_B = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP   = 2'd3;

  // Reset values
  localparam logic [PULSE_W-1:0] PULSE_MIN_RST   = 12'd800;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST   = 12'd2000;
  localparam logic [STEP_W-1:0]  COARSE_STEP_RST = 8'd10;
  localparam logic [STEP_W-1:0]  FINE_STEP_RST   = 8'd3;
  localparam logic [TRIM_W-1:0]  TRIM_RST        = 12'd1500;
  localparam logic [GAIN_W-1:0]  GAIN_RST        = 8'd150;

  // Switch and knob levels
  localparam logic signed [CH_W-1:0] SW_LOW       = -8'sd100;
  localparam logic signed [CH_W-1:0] SW_MID       = 8'sd0;
  localparam logic signed [CH_W-1:0] SW_HIGH      = 8'sd100;
  localparam logic signed [CH_W-1:0] KNOB_SAT_MIN = 8'sd106;
  localparam logic signed [9:0]      GAIN_BASE    = 10'sd150;
  localparam logic [GAIN_W-1:0]      GAIN_SAT     = 8'd255;
  localparam logic [TRIM_W-1:0]      TRIM_TOP     = 12'd4095;

  // floor(n / 50) = (n * DIV50_RECIP) >> DIV50_SHIFT, exact for n < 2^18
  localparam int NUM_W        = 19;
  localparam int QUOT_W       = 13;
  localparam int DIV50_SHIFT  = 24;
  localparam logic [18:0] DIV50_RECIP = 19'd335545;
  localparam logic [5:0]  GAIN_DEN    = 6'd50;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [STEP_W-1:0] coarse;
    logic [STEP_W-1:0] fine;
  } steps_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pmin;
    logic [PULSE_W-1:0] pmax;
  } limits_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic signed [CH_W-1:0] pitch;
    logic signed [CH_W-1:0] yaw;
    logic [GAIN_W-1:0]      gain_a;
    logic [GAIN_W-1:0]      gain_b;
    logic [TRIM_W-1:0]      trim_a;
    logic [TRIM_W-1:0]      trim_b;
    logic [MODE_W-1:0]      mode;
    logic                   lock;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/core/stm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface stm_frame_if;
  logic                                valid;
  logic                                ready;
  logic signed [stm_pkg::CH_W-1:0]     pitch_stick;
  logic signed [stm_pkg::CH_W-1:0]     yaw_stick;
  logic signed [stm_pkg::CH_W-1:0]     button_a;
  logic signed [stm_pkg::CH_W-1:0]     button_b;
  logic signed [stm_pkg::CH_W-1:0]     mode_switch;
  logic signed [stm_pkg::CH_W-1:0]     knob_a;
  logic signed [stm_pkg::CH_W-1:0]     knob_b;
  logic signed [stm_pkg::CH_W-1:0]     gauge_switch;

  modport source (
    output valid, pitch_stick, yaw_stick, button_a, button_b, mode_switch,
           knob_a, knob_b, gauge_switch,
    input  ready
  );
  modport sink (
    input  valid, pitch_stick, yaw_stick, button_a, button_b, mode_switch,
           knob_a, knob_b, gauge_switch,
    output ready
  );
endinterface

interface stm_result_if;
  logic                          valid;
  logic                          ready;
  logic [stm_pkg::PULSE_W-1:0]   pulse_a;
  logic [stm_pkg::PULSE_W-1:0]   pulse_b;
  logic [stm_pkg::MODE_W-1:0]    mode_now;
  logic                          locked;
  logic [stm_pkg::TRIM_W-1:0]    trim_a_now;
  logic [stm_pkg::TRIM_W-1:0]    trim_b_now;

  modport source (
    output valid, pulse_a, pulse_b, mode_now, locked, trim_a_now, trim_b_now,
    input  ready
  );
  modport sink (
    input  valid, pulse_a, pulse_b, mode_now, locked, trim_a_now, trim_b_now,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/stm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stm_front (
  input  logic            clk,
  input  logic            rst,
  stm_frame_if.sink       frame,
  input  stm_pkg::steps_t steps,
  input  stm_pkg::qstat_t qstat,
  output logic            push,
  output stm_pkg::job_t   job
);
  import stm_pkg::*;

  // Button level: floor((v + 100) / 100), zero below range
  function automatic logic [1:0] button_level(input logic signed [CH_W-1:0] v);
    logic [1:0] lvl;
    if (v >= SW_HIGH) begin
      lvl = 2'd2;
    end else if (v >= SW_MID) begin
      lvl = 2'd1;
    end else begin
      lvl = 2'd0;
    end
    return lvl;
  endfunction

  function automatic logic [GAIN_W-1:0] knob_gain(input logic signed [CH_W-1:0] v);
    logic signed [9:0] g;
    logic [GAIN_W-1:0] r;
    g = GAIN_BASE + 10'(v);
    if (v >= KNOB_SAT_MIN) begin
      r = GAIN_SAT;
    end else begin
      r = g[GAIN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [TRIM_W-1:0] trim_add(input logic [TRIM_W-1:0] t,
                                                 input logic [STEP_W-1:0] s,
                                                 input logic dn);
    logic signed [TRIM_W+1:0] r;
    logic [TRIM_W-1:0]        o;
    if (dn) begin
      r = $signed({2'b00, t}) - $signed({6'd0, s});
    end else begin
      r = $signed({2'b00, t}) + $signed({6'd0, s});
    end
    if (r < 0) begin
      o = '0;
    end else if (r > $signed({2'b00, TRIM_TOP})) begin
      o = TRIM_TOP;
    end else begin
      o = r[TRIM_W-1:0];
    end
    return o;
  endfunction

  logic [MODE_W-1:0] mode, mode_next;
  logic              lock, lock_next;
  logic [TRIM_W-1:0] trim_a, trim_a_next, trim_b, trim_b_next, trim_sel, trim_new;
  logic [GAIN_W-1:0] gain_a, gain_a_next, gain_b, gain_b_next;
  logic              accept, gauging, hit, dn, fine;
  logic [1:0]        la, lb;
  logic [STEP_W-1:0] step;

  assign frame.ready = !qstat.full && !rst;
  assign accept      = frame.valid && frame.ready;

  always_comb begin
    priority if (frame.mode_switch == SW_LOW) begin
      mode_next = MODE_MOVING;
    end else if (frame.mode_switch == SW_MID) begin
      mode_next = MODE_TRIM_A;
    end else if (frame.mode_switch == SW_HIGH) begin
      mode_next = MODE_TRIM_B;
    end else begin
      mode_next = mode;
    end
  end

  // Button decode: one button alone at level 1 or 2 picks the step
  always_comb begin
    gauging = frame.gauge_switch != SW_LOW;
    la      = button_level(frame.button_a);
    lb      = button_level(frame.button_b);
    hit     = 1'b0;
    dn      = 1'b0;
    fine    = 1'b0;
    unique case ({la, lb})
      {2'd1, 2'd0}: begin hit = 1'b1; end
      {2'd2, 2'd0}: begin hit = 1'b1; dn = 1'b1; end
      {2'd0, 2'd1}: begin hit = 1'b1; fine = 1'b1; end
      {2'd0, 2'd2}: begin hit = 1'b1; fine = 1'b1; dn = 1'b1; end
      default: begin hit = 1'b0; end
    endcase
    step     = fine ? steps.fine : steps.coarse;
    trim_sel = (mode_next == MODE_TRIM_B) ? trim_b : trim_a;
    trim_new = trim_add(trim_sel, step, dn);
  end

  always_comb begin
    lock_next   = lock;
    trim_a_next = trim_a;
    trim_b_next = trim_b;
    gain_a_next = gain_a;
    gain_b_next = gain_b;
    if (mode_next == MODE_TRIM_A || mode_next == MODE_TRIM_B) begin
      if (!lock) begin
        if (gauging && hit) begin
          lock_next = 1'b1;
          if (mode_next == MODE_TRIM_B) begin
            trim_b_next = trim_new;
          end else begin
            trim_a_next = trim_new;
          end
        end
        if (mode_next == MODE_TRIM_B) begin
          gain_b_next = knob_gain(frame.knob_b);
        end else begin
          gain_a_next = knob_gain(frame.knob_a);
        end
      end else if (!gauging) begin
        lock_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_MOVING;
      lock   <= 1'b0;
      trim_a <= TRIM_RST;
      trim_b <= TRIM_RST;
      gain_a <= GAIN_RST;
      gain_b <= GAIN_RST;
    end else if (accept) begin
      mode   <= mode_next;
      lock   <= lock_next;
      trim_a <= trim_a_next;
      trim_b <= trim_b_next;
      gain_a <= gain_a_next;
      gain_b <= gain_b_next;
    end
  end

  assign push = accept;

  always_comb begin
    job.pitch  = frame.pitch_stick;
    job.yaw    = frame.yaw_stick;
    job.gain_a = gain_a_next;
    job.gain_b = gain_b_next;
    job.trim_a = trim_a_next;
    job.trim_b = trim_b_next;
    job.mode   = mode_next;
    job.lock   = lock_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/stm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stm_pkg::job_t   wr_job,
  input  logic            pop,
  output stm_pkg::job_t   rd_job,
  output logic            rd_valid,
  output stm_pkg::qstat_t qstat
);
  import stm_pkg::*;

  job_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign qstat.full  = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign rd_valid    = !qstat.empty;
  assign rd_job      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module stm_back (
  input  logic             clk,
  input  logic             rst,
  input  stm_pkg::job_t    job,
  input  logic             job_valid,
  output logic             pop,
  input  stm_pkg::limits_t limits,
  stm_result_if.source     result
);
  import stm_pkg::*;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              lock;
    logic [TRIM_W-1:0] trim_a;
    logic [TRIM_W-1:0] trim_b;
  } tail_t;

  // stick * g + 50 * trim
  function automatic logic signed [NUM_W-1:0] pulse_num(input logic signed [CH_W-1:0] s,
                                                         input logic [GAIN_W-1:0] g,
                                                         input logic [TRIM_W-1:0] t);
    logic signed [CH_W+GAIN_W:0] sg;
    logic [NUM_W-2:0]            t50;
    sg  = s * $signed({1'b0, g});
    t50 = (NUM_W-1)'(t) * (NUM_W-1)'(GAIN_DEN);
    return NUM_W'(sg) + $signed({1'b0, t50});
  endfunction

  function automatic logic [PULSE_W-1:0] clamp(input logic neg,
                                               input logic [QUOT_W-1:0] q,
                                               input limits_t lim);
    logic [QUOT_W-1:0] p;
    if (neg) begin
      p = {1'b0, lim.pmin};
    end else begin
      p = q;
      if (p > {1'b0, lim.pmax}) begin
        p = {1'b0, lim.pmax};
      end
      if (p < {1'b0, lim.pmin}) begin
        p = {1'b0, lim.pmin};
      end
    end
    return p[PULSE_W-1:0];
  endfunction

  logic                    adv;
  logic                    s1_valid, s2_valid, out_valid;
  logic signed [NUM_W-1:0] s1_num_a, s1_num_b;
  tail_t                   s1_tail, s2_tail, out_tail;
  logic                    s2_neg_a, s2_neg_b;
  logic [QUOT_W-1:0]       s2_q_a, s2_q_b;
  logic [36:0]             prod_a, prod_b;
  logic [PULSE_W-1:0]      out_pulse_a, out_pulse_b;

  // Advance the whole pipe together whenever the output slot frees
  assign adv = !out_valid || result.ready;
  assign pop = adv && job_valid;

  assign prod_a = 37'(s1_num_a[NUM_W-2:0]) * 37'(DIV50_RECIP);
  assign prod_b = 37'(s1_num_b[NUM_W-2:0]) * 37'(DIV50_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= job_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_num_a       <= pulse_num(job.pitch, job.gain_a, job.trim_a);
      s1_num_b       <= pulse_num(job.yaw, job.gain_b, job.trim_b);
      s1_tail.mode   <= job.mode;
      s1_tail.lock   <= job.lock;
      s1_tail.trim_a <= job.trim_a;
      s1_tail.trim_b <= job.trim_b;
      s2_neg_a       <= s1_num_a[NUM_W-1];
      s2_neg_b       <= s1_num_b[NUM_W-1];
      s2_q_a         <= prod_a[DIV50_SHIFT +: QUOT_W];
      s2_q_b         <= prod_b[DIV50_SHIFT +: QUOT_W];
      s2_tail        <= s1_tail;
      out_pulse_a    <= clamp(s2_neg_a, s2_q_a, limits);
      out_pulse_b    <= clamp(s2_neg_b, s2_q_b, limits);
      out_tail       <= s2_tail;
    end
  end

  assign result.valid      = out_valid;
  assign result.pulse_a    = out_pulse_a;
  assign result.pulse_b    = out_pulse_b;
  assign result.mode_now   = out_tail.mode;
  assign result.locked     = out_tail.lock;
  assign result.trim_a_now = out_tail.trim_a;
  assign result.trim_b_now = out_tail.trim_b;

endmodule

`default_nettype wire

// ----- rtl/core/servo_trim_mapper.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Servo trim mapper: one radio frame in, one pair of servo pulse widths out.
//
// frame  : valid/ready channel; one word holds both sticks, both trim buttons,
//          the mode switch, both gain knobs and the gauge switch.
// result : valid/ready channel; one word per frame with both clamped pulses,
//          the mode, the lock flag and both trims after that frame's update.
// cfg_*  : write port for pulse_min, pulse_max, coarse_step, fine_step; write
//          only while no frame is in flight.
//
// The front updates mode, lock, trims and gains in the cycle a word is taken
// and pushes a job into a four-entry queue. The back runs three stages: the
// stick*gain + 50*trim multiply-add, the divide by 50 as a reciprocal
// multiply, then the clamp into the output register.
// A taken word enters the queue, then the s1, s2 and output registers.
// Throughput: one word per cycle while the queue is not full.
// When result.ready drops the back holds, the queue fills and frame.ready
// falls once four words are waiting. Reset loads the default limits and
// steps, moving mode, unlocked, trims 1500 and gains 3.0, and empties the
// queue and pipe; frame.ready stays low during reset.

module servo_trim_mapper (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [stm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]   cfg_data,
  stm_frame_if.sink                        frame,
  stm_result_if.source                     result
);
  import stm_pkg::*;

  logic [PULSE_W-1:0] pulse_min, pulse_max;
  logic [STEP_W-1:0]  coarse_step, fine_step;
  steps_t             steps;
  limits_t            limits;
  qstat_t             qstat;
  job_t               push_job, pop_job;
  logic               push, pop, job_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min   <= PULSE_MIN_RST;
      pulse_max   <= PULSE_MAX_RST;
      coarse_step <= COARSE_STEP_RST;
      fine_step   <= FINE_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_MIN:   pulse_min   <= cfg_data[PULSE_W-1:0];
        CFG_PULSE_MAX:   pulse_max   <= cfg_data[PULSE_W-1:0];
        CFG_COARSE_STEP: coarse_step <= cfg_data[STEP_W-1:0];
        CFG_FINE_STEP:   fine_step   <= cfg_data[STEP_W-1:0];
      endcase
    end
  end

  assign steps.coarse = coarse_step;
  assign steps.fine   = fine_step;
  assign limits.pmin  = pulse_min;
  assign limits.pmax  = pulse_max;

  // Front: take the frame, update the trim state, hand off a job
  stm_front u_front (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .steps (steps),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  // Queue: let front and back stall independently
  stm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (push_job),
    .pop      (pop),
    .rd_job   (pop_job),
    .rd_valid (job_valid),
    .qstat    (qstat)
  );

  // Back: compute and clamp the pulses, drive the result word
  stm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_job),
    .job_valid (job_valid),
    .pop       (pop),
    .limits    (limits),
    .result    (result)
  );

  // No result left over from before reset
  a_reset_drains: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // Queue flags never contradict each other
  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue both full and empty");

  // A taken word always lands in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready) |=> !qstat.empty)
    else $error("accepted word missing from queue");

endmodule

`default_nettype wire

// ----- test/servo_trim_mapper_tb.sv -----
`timescale 1ns / 1ps

module servo_trim_mapper_tb;
  import stm_pkg::*;

  // Button codes: level(a) * 4 + level(b) * 5 picks the trim action.
  localparam int CODE_COARSE_UP   = 4;
  localparam int CODE_COARSE_DOWN = 8;
  localparam int CODE_FINE_UP     = 5;
  localparam int CODE_FINE_DOWN   = 10;

  typedef struct {
    logic signed [CH_W-1:0] pitch_stick;
    logic signed [CH_W-1:0] yaw_stick;
    logic signed [CH_W-1:0] button_a;
    logic signed [CH_W-1:0] button_b;
    logic signed [CH_W-1:0] mode_switch;
    logic signed [CH_W-1:0] knob_a;
    logic signed [CH_W-1:0] knob_b;
    logic signed [CH_W-1:0] gauge_switch;
  } frame_t;

  typedef struct {
    logic [PULSE_W-1:0] pulse_a;
    logic [PULSE_W-1:0] pulse_b;
    logic [MODE_W-1:0]  mode_now;
    logic               locked;
    logic [TRIM_W-1:0]  trim_a_now;
    logic [TRIM_W-1:0]  trim_b_now;
  } servo_out_t;

  // Tracks mode, lock, trims and gains word by word, and holds the servo
  // outputs still owed by the block in arrival order.
  class trim_tracker;
    logic [PULSE_W-1:0] pulse_min, pulse_max;
    logic [STEP_W-1:0]  coarse_step, fine_step;
    logic [MODE_W-1:0]  mode;
    logic               lock;
    logic [TRIM_W-1:0]  trim_a, trim_b;
    logic [GAIN_W-1:0]  gain_a, gain_b;
    servo_out_t         servo_out_q[$];
    int                 errors;

    function new();
      pulse_min   = PULSE_MIN_RST;
      pulse_max   = PULSE_MAX_RST;
      coarse_step = COARSE_STEP_RST;
      fine_step   = FINE_STEP_RST;
      mode        = MODE_MOVING;
      lock        = 1'b0;
      trim_a      = TRIM_RST;
      trim_b      = TRIM_RST;
      gain_a      = GAIN_RST;
      gain_b      = GAIN_RST;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PULSE_MIN:   pulse_min = value;
        CFG_PULSE_MAX:   pulse_max = value;
        CFG_COARSE_STEP: coarse_step = value[STEP_W-1:0];
        CFG_FINE_STEP:   fine_step = value[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function int level(logic signed [CH_W-1:0] v);
      int s;
      s = int'(v) + 100;
      return (s < 0) ? 0 : s / 100;
    endfunction

    // Saturate the trim into 0..4095.
    function logic [TRIM_W-1:0] nudge(logic [TRIM_W-1:0] t, int d);
      int r;
      r = int'(t) + d;
      if (r < 0) r = 0;
      if (r > int'(TRIM_TOP)) r = int'(TRIM_TOP);
      return r[TRIM_W-1:0];
    endfunction

    // floor(stick * g / 50 + trim); max clamp first so pulse_min wins.
    function logic [PULSE_W-1:0] pulse(logic signed [CH_W-1:0] stick,
                                       logic [GAIN_W-1:0] g, logic [TRIM_W-1:0] t);
      int num, p;
      num = int'(stick) * int'(g) + int'(GAIN_DEN) * int'(t);
      if (num < 0) return pulse_min;
      p = num / int'(GAIN_DEN);
      if (p > int'(pulse_max)) p = int'(pulse_max);
      if (p < int'(pulse_min)) p = int'(pulse_min);
      return p[PULSE_W-1:0];
    endfunction

    function void apply_frame(frame_t f);
      servo_out_t             o;
      logic [TRIM_W-1:0]      t;
      logic signed [CH_W-1:0] kv;
      bit                     gauging;
      int                     code, k;
      if (f.mode_switch == SW_LOW) mode = MODE_MOVING;
      else if (f.mode_switch == SW_MID) mode = MODE_TRIM_A;
      else if (f.mode_switch == SW_HIGH) mode = MODE_TRIM_B;
      gauging = (f.gauge_switch != SW_LOW);
      if (mode != MODE_MOVING) begin
        t  = (mode == MODE_TRIM_A) ? trim_a : trim_b;
        kv = (mode == MODE_TRIM_A) ? f.knob_a : f.knob_b;
        if (!lock) begin
          if (gauging) begin
            code = level(f.button_a) * 4 + level(f.button_b) * 5;
            case (code)
              CODE_COARSE_UP: begin
                t = nudge(t, int'(coarse_step));
                lock = 1'b1;
              end
              CODE_COARSE_DOWN: begin
                t = nudge(t, -int'(coarse_step));
                lock = 1'b1;
              end
              CODE_FINE_UP: begin
                t = nudge(t, int'(fine_step));
                lock = 1'b1;
              end
              CODE_FINE_DOWN: begin
                t = nudge(t, -int'(fine_step));
                lock = 1'b1;
              end
              default: ;
            endcase
          end
          // Reload the gain of the trimmed servo even with the gauge off.
          k = int'(GAIN_BASE) + int'(kv);
          if (k > int'(GAIN_SAT)) k = int'(GAIN_SAT);
          if (mode == MODE_TRIM_A) gain_a = k[GAIN_W-1:0];
          else gain_b = k[GAIN_W-1:0];
        end else if (!gauging) begin
          lock = 1'b0;
        end
        if (mode == MODE_TRIM_A) trim_a = t;
        else trim_b = t;
      end
      o.pulse_a    = pulse(f.pitch_stick, gain_a, trim_a);
      o.pulse_b    = pulse(f.yaw_stick, gain_b, trim_b);
      o.mode_now   = mode;
      o.locked     = lock;
      o.trim_a_now = trim_a;
      o.trim_b_now = trim_b;
      servo_out_q.push_back(o);
    endfunction

    function void compare_field(string field, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_servo_out(servo_out_t got);
      servo_out_t want;
      if (servo_out_q.size() == 0) begin
        $error("result word with nothing pending: pulse_a %0d pulse_b %0d",
               got.pulse_a, got.pulse_b);
        errors++;
        return;
      end
      want = servo_out_q.pop_front();
      compare_field("pulse_a", want.pulse_a, got.pulse_a);
      compare_field("pulse_b", want.pulse_b, got.pulse_b);
      compare_field("mode_now", 12'(want.mode_now), 12'(got.mode_now));
      compare_field("locked", 12'(want.locked), 12'(got.locked));
      compare_field("trim_a_now", want.trim_a_now, got.trim_a_now);
      compare_field("trim_b_now", want.trim_b_now, got.trim_b_now);
    endfunction

    function int pending();
      return servo_out_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stm_frame_if  frame_ch ();
  stm_result_if result_ch ();

  servo_trim_mapper dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame_ch),
    .result    (result_ch)
  );

  trim_tracker tracker;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          frames_sent;

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops words.
  initial begin
    #6_000_000;
    $display("servo_trim_mapper_tb: done, errors");
    $finish;
  end

  // Receiver: drop ready at random according to the current stall rate.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on every accepted frame word. Values read here are the ones the
  // block saw at this edge; all drives land in the NBA region afterwards.
  always @(posedge clk) begin : take_frame
    frame_t f;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      f.pitch_stick  = frame_ch.pitch_stick;
      f.yaw_stick    = frame_ch.yaw_stick;
      f.button_a     = frame_ch.button_a;
      f.button_b     = frame_ch.button_b;
      f.mode_switch  = frame_ch.mode_switch;
      f.knob_a       = frame_ch.knob_a;
      f.knob_b       = frame_ch.knob_b;
      f.gauge_switch = frame_ch.gauge_switch;
      tracker.apply_frame(f);
    end
  end

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk) begin : take_result
    servo_out_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.pulse_a    = result_ch.pulse_a;
      got.pulse_b    = result_ch.pulse_b;
      got.mode_now   = result_ch.mode_now;
      got.locked     = result_ch.locked;
      got.trim_a_now = result_ch.trim_a_now;
      got.trim_b_now = result_ch.trim_b_now;
      tracker.check_servo_out(got);
    end
  end

  function automatic logic signed [CH_W-1:0] rand_ch();
    logic [31:0] r;
    int          v;
    r = $urandom;
    v = int'($urandom_range(200)) - 100;
    // Mostly in the nominal range, sometimes anywhere in the byte.
    return ($urandom_range(3) == 0) ? r[CH_W-1:0] : v[CH_W-1:0];
  endfunction

  // Any switch value that leaves the mode alone.
  function automatic logic signed [CH_W-1:0] keep_value();
    logic signed [CH_W-1:0] v;
    do begin
      v = CH_W'($urandom);
    end while (v == SW_LOW || v == SW_MID || v == SW_HIGH);
    return v;
  endfunction

  // Random button value giving level 0, 1 or 2.
  function automatic logic signed [CH_W-1:0] btn_value(int lvl);
    int v;
    case (lvl)
      0:       v = int'($urandom_range(127)) - 128;
      1:       v = int'($urandom_range(99));
      default: v = 100 + int'($urandom_range(27));
    endcase
    return v[CH_W-1:0];
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    f.pitch_stick  = rand_ch();
    f.yaw_stick    = rand_ch();
    f.button_a     = rand_ch();
    f.button_b     = rand_ch();
    f.mode_switch  = rand_ch();
    f.knob_a       = rand_ch();
    f.knob_b       = rand_ch();
    f.gauge_switch = ($urandom_range(3) == 0) ? SW_LOW : rand_ch();
    return f;
  endfunction

  function automatic frame_t mk(int pitch, int yaw, int ba, int bb, int msw,
                                int ka, int kb, int gauge);
    frame_t f;
    f.pitch_stick  = pitch[CH_W-1:0];
    f.yaw_stick    = yaw[CH_W-1:0];
    f.button_a     = ba[CH_W-1:0];
    f.button_b     = bb[CH_W-1:0];
    f.mode_switch  = msw[CH_W-1:0];
    f.knob_a       = ka[CH_W-1:0];
    f.knob_b       = kb[CH_W-1:0];
    f.gauge_switch = gauge[CH_W-1:0];
    return f;
  endfunction

  // Hold off at random, then present the word until it is taken.
  task automatic send_frame(input frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk);
    end
    frame_ch.valid        <= 1'b1;
    frame_ch.pitch_stick  <= f.pitch_stick;
    frame_ch.yaw_stick    <= f.yaw_stick;
    frame_ch.button_a     <= f.button_a;
    frame_ch.button_b     <= f.button_b;
    frame_ch.mode_switch  <= f.mode_switch;
    frame_ch.knob_a       <= f.knob_a;
    frame_ch.knob_b       <= f.knob_b;
    frame_ch.gauge_switch <= f.gauge_switch;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    frames_sent++;
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic drain();
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Keep cfg_we high across back-to-back writes; lower it once at the end.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic program_limits(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi,
                                input logic [STEP_W-1:0] coarse,
                                input logic [STEP_W-1:0] fine);
    write_cfg(CFG_PULSE_MIN, lo);
    write_cfg(CFG_PULSE_MAX, hi);
    write_cfg(CFG_COARSE_STEP, CFG_DATA_W'(coarse));
    write_cfg(CFG_FINE_STEP, CFG_DATA_W'(fine));
    cfg_we <= 1'b0;
  endtask

  initial begin
    frame_t word;
    int     pick, target, half, presses, la, lb;
    bit     paused, on_b;

    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    frames_sent    = 0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    frame_ch.valid        = 1'b0;
    frame_ch.pitch_stick  = '0;
    frame_ch.yaw_stick    = '0;
    frame_ch.button_a     = '0;
    frame_ch.button_b     = '0;
    frame_ch.mode_switch  = '0;
    frame_ch.knob_a       = '0;
    frame_ch.knob_b       = '0;
    frame_ch.gauge_switch = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset limits and steps, no idling.
    // Moving mode, full sticks, then the byte extremes on every channel.
    send_frame(mk(100, -100, -100, -100, SW_LOW, 0, 0, SW_LOW));
    send_frame(mk(-128, 127, -128, 127, SW_LOW, 127, -128, -128));
    // Trim A coarse up with a saturating knob; lock sets.
    send_frame(mk(0, 0, 0, -100, SW_MID, 127, 0, 0));
    // Locked: buttons and knob do nothing while the gauge stays on.
    send_frame(mk(50, 50, 0, -100, SW_MID, -50, 0, 100));
    // Release the gauge to clear the lock.
    send_frame(mk(50, 50, 0, 0, SW_MID, 0, 0, SW_LOW));
    // Trim A coarse down, smallest knob.
    send_frame(mk(-100, 0, 100, -100, SW_MID, -128, 0, 1));
    send_frame(mk(-100, 0, 0, 0, SW_MID, 0, 0, SW_LOW));
    // Trim B fine up, knob at the edge of saturation.
    send_frame(mk(0, 100, -1, 0, SW_HIGH, 0, 105, 0));
    send_frame(mk(0, 100, 0, 0, SW_HIGH, 0, 0, SW_LOW));
    // Trim B fine down, knob just past saturation.
    send_frame(mk(0, -100, -100, 100, SW_HIGH, 0, 106, 127));
    // Off-level switch values keep trim B.
    send_frame(mk(0, -100, 0, 0, 37, 0, -37, SW_LOW));
    // Unlocked with the gauge off: gain reloads, buttons ignored.
    send_frame(mk(90, -90, 0, -100, -1, 0, -60, SW_LOW));
    // Buttons below range, both at level one, both at level two.
    send_frame(mk(10, 10, -128, -128, SW_MID, 20, 0, 5));
    send_frame(mk(10, 10, 0, 0, SW_MID, -20, 0, 5));
    send_frame(mk(10, 10, 127, 127, SW_MID, 0, 0, 5));
    // Lock in trim A, then hold it through moving mode.
    send_frame(mk(10, 10, 99, -100, SW_MID, 0, 0, 5));
    send_frame(mk(100, 100, 0, -100, SW_LOW, 0, 0, SW_LOW));
    send_frame(mk(100, 100, 0, -100, -128, 0, 0, SW_LOW));
    // Locked in trim B with gauge on, then release there.
    send_frame(mk(100, 100, 0, -100, SW_HIGH, 0, 0, 50));
    send_frame(mk(100, 100, 0, -100, SW_HIGH, 0, 0, SW_LOW));

    // Random phases, each setting limits, steps and an idling pattern.
    for (int p = 0; p < 8; p++) begin
      drain();
      repeat (4) @(posedge clk);
      case (p % 5)
        0: program_limits(PULSE_MIN_RST, PULSE_MAX_RST, COARSE_STEP_RST, FINE_STEP_RST);
        1: program_limits(12'd0, TRIM_TOP, 8'd255, 8'd255);
        2: program_limits(12'd1700, 12'd1300, 8'd0, 8'd1);
        3: program_limits(TRIM_TOP, 12'd0, 8'd255, 8'd0);
        default: program_limits(PULSE_W'($urandom_range(2000)),
                                PULSE_W'($urandom_range(4095, 1000)),
                                STEP_W'($urandom_range(255)),
                                STEP_W'($urandom_range(255)));
      endcase
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      target = frames_sent + 225;
      half   = frames_sent + 110;
      paused = 1'b0;
      while (frames_sent < target) begin
        // Halfway through, hold the sender until the pipe is empty.
        if (!paused && frames_sent >= half) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
          // A run of press/release pairs in one direction on one servo,
          // long enough at big steps to drive a trim into saturation.
          on_b    = 1'($urandom_range(1));
          presses = $urandom_range(16, 1);
          case ($urandom_range(3))
            0: begin la = 1; lb = 0; end
            1: begin la = 2; lb = 0; end
            2: begin la = 0; lb = 1; end
            default: begin la = 0; lb = 2; end
          endcase
          for (int i = 0; i < presses; i++) begin
            word = rand_frame();
            if (i > 0 && $urandom_range(3) == 0) word.mode_switch = keep_value();
            else word.mode_switch = on_b ? SW_HIGH : SW_MID;
            if (word.gauge_switch == SW_LOW) word.gauge_switch = SW_MID;
            word.button_a = btn_value(la);
            word.button_b = btn_value(lb);
            send_frame(word);
            word = rand_frame();
            word.gauge_switch = SW_LOW;
            case ($urandom_range(3))
              0, 1:    word.mode_switch = on_b ? SW_HIGH : SW_MID;
              2:       word.mode_switch = keep_value();
              default: word.mode_switch = SW_LOW;
            endcase
            send_frame(word);
          end
        end else if (pick < 85) begin
          word = rand_frame();
          if ($urandom_range(1)) word.mode_switch = SW_LOW;
          send_frame(word);
        end else begin
          // Raw bytes on every channel.
          {word.pitch_stick, word.yaw_stick, word.button_a, word.button_b} = $urandom;
          {word.mode_switch, word.knob_a, word.knob_b, word.gauge_switch} = $urandom;
          send_frame(word);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("servo_trim_mapper_tb: done, clean");
    end else begin
      $display("servo_trim_mapper_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- servo_trim_mapper.f -----
rtl/core/stm_pkg.sv
rtl/core/stm_if.sv
rtl/core/stm_front.sv
rtl/core/stm_queue.sv
rtl/core/stm_back.sv
rtl/core/servo_trim_mapper.sv
test/servo_trim_mapper_tb.sv
